>>> hw/rtl/websocket_frame_deframer_macros.svh
// Assertion macros shared by the checker of the frame deframer.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define WSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/wsd_pkg.sv
// Package for the frame deframer: payload structs, config struct and codes.
// No dependencies.
package wsd_pkg;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       frame_last;
        logic [1:0] control_action;
        logic [2:0] error_code;
        logic       closed;
    } out_t;

    typedef struct packed {
        logic        role_client;
        logic [31:0] max_frame_length;
    } cfg_t;

    // register indexes
    localparam logic REG_ROLE_CLIENT = 1'b0;
    localparam logic REG_MAX_LENGTH  = 1'b1;
    localparam logic [31:0] MAX_LENGTH_RESET = 32'd67108864;

    // event kinds
    localparam logic [1:0] EV_BYTE       = 2'd0;
    localparam logic [1:0] EV_CLOSE_SENT = 2'd1;
    localparam logic [1:0] EV_STREAM_END = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_CONTROL = 3'd2;
    localparam logic [2:0] KIND_ERROR   = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    // control actions
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_PONG      = 2'd1;
    localparam logic [1:0] ACT_CLOSE     = 2'd2;
    localparam logic [1:0] ACT_PONG_SEEN = 2'd3;

    // error codes
    localparam logic [2:0] ERR_RESERVED   = 3'd0;
    localparam logic [2:0] ERR_MASK_ROLE  = 3'd1;
    localparam logic [2:0] ERR_BAD_CTRL   = 3'd2;
    localparam logic [2:0] ERR_DATA_OP    = 3'd3;
    localparam logic [2:0] ERR_OVERSIZE   = 3'd4;
    localparam logic [2:0] ERR_UNKNOWN_OP = 3'd5;

    // opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // length codes in the second header byte
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

endpackage

>>> hw/rtl/wsd_cfg.sv
// APB-style configuration registers of the frame deframer.
// Depends on wsd_pkg.
module wsd_cfg
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic        role_client_reg;
    logic [31:0] max_frame_length_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_client_reg      <= 1'b0;
            max_frame_length_reg <= MAX_LENGTH_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_ROLE_CLIENT: role_client_reg      <= pwdata[0];
                REG_MAX_LENGTH:  max_frame_length_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROLE_CLIENT: prdata = {31'd0, role_client_reg};
            REG_MAX_LENGTH:  prdata = max_frame_length_reg;
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.role_client      = role_client_reg;
    assign cfg.max_frame_length = max_frame_length_reg;

endmodule

>>> hw/rtl/wsd_core.sv
// Frame parser state and the per-byte step logic of the deframer.
// Depends on wsd_pkg; result is registered by wsd_out.
module wsd_core
    import wsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  in_t  item,
    input  cfg_t cfg,
    output out_t res
);

    localparam logic [2:0] PH_BYTE0   = 3'd0;
    localparam logic [2:0] PH_BYTE1   = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_KEY     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;

    logic [2:0]  parse_phase_reg, parse_phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [3:0]  saved_opcode_reg, saved_opcode_next;
    logic        saved_fin_reg, saved_fin_next;
    logic        saved_masked_reg, saved_masked_next;
    logic [2:0]  saved_reserved_reg, saved_reserved_next;
    logic [63:0] length_accumulator_reg, length_accumulator_next;
    logic [31:0] mask_key_reg, mask_key_next;
    logic [1:0]  mask_position_reg, mask_position_next;
    logic [63:0] bytes_remaining_reg, bytes_remaining_next;
    logic        frame_is_control_reg, frame_is_control_next;
    logic        close_received_reg, close_received_next;
    logic        close_sent_reg, close_sent_next;
    logic        error_latched_reg, error_latched_next;
    logic [2:0]  latched_code_reg, latched_code_next;

    logic [7:0]  b;
    logic [3:0]  hdr_idx_inc;
    logic [63:0] acc_shift;
    logic [7:0]  key_byte;
    logic        rem_last;

    // shared end-of-header check
    logic        hd_go;
    logic [63:0] hd_len;
    logic        hd_masked;
    logic        hd_ctl;
    logic        hd_bad;
    logic [2:0]  hd_code;
    logic        ctrl_end;

    logic [2:0]  o_kind;
    logic [7:0]  o_byte;
    logic        o_last;
    logic [1:0]  o_action;
    logic [2:0]  o_err;

    assign b           = item.rx_byte;
    assign hdr_idx_inc = header_index_reg + 4'd1;
    assign acc_shift   = {length_accumulator_reg[55:0], b};
    assign key_byte    = mask_key_reg[{~mask_position_reg, 3'b000} +: 8];
    assign rem_last    = (bytes_remaining_reg[63:1] == 63'd0);
    assign hd_ctl      = saved_opcode_reg[3];

    always_comb
    begin
        hd_bad  = 1'b1;
        hd_code = ERR_MASK_ROLE;
        if (cfg.role_client == hd_masked)
            hd_code = ERR_MASK_ROLE;
        else if (hd_ctl && (!saved_fin_reg || hd_len > CTRL_MAX_LEN))
            hd_code = ERR_BAD_CTRL;
        else if (!hd_ctl && saved_opcode_reg != OP_BINARY && saved_opcode_reg != OP_CONT)
            hd_code = ERR_DATA_OP;
        else if (hd_len > {32'd0, cfg.max_frame_length})
            hd_code = ERR_OVERSIZE;
        else
            hd_bad = 1'b0;
    end

    always_comb
    begin
        parse_phase_next        = parse_phase_reg;
        header_index_next       = header_index_reg;
        saved_opcode_next       = saved_opcode_reg;
        saved_fin_next          = saved_fin_reg;
        saved_masked_next       = saved_masked_reg;
        saved_reserved_next     = saved_reserved_reg;
        length_accumulator_next = length_accumulator_reg;
        mask_key_next           = mask_key_reg;
        mask_position_next      = mask_position_reg;
        bytes_remaining_next    = bytes_remaining_reg;
        frame_is_control_next   = frame_is_control_reg;
        close_received_next     = close_received_reg;
        close_sent_next         = close_sent_reg;
        error_latched_next      = error_latched_reg;
        latched_code_next       = latched_code_reg;

        o_kind    = KIND_NONE;
        o_byte    = 8'd0;
        o_last    = 1'b0;
        o_action  = ACT_NONE;
        o_err     = 3'd0;
        hd_go     = 1'b0;
        hd_len    = length_accumulator_reg;
        hd_masked = saved_masked_reg;
        ctrl_end  = 1'b0;

        if (item.event_kind == EV_CLOSE_SENT)
            close_sent_next = 1'b1;
        else if (item.event_kind == EV_STREAM_END)
            close_received_next = 1'b1;
        else if (item.event_kind == EV_BYTE)
        begin
            if (error_latched_reg)
            begin
                o_kind = KIND_ERROR;
                o_err  = latched_code_reg;
            end
            else if (close_received_reg)
                o_kind = KIND_IGNORED;
            else
            begin
                unique case (parse_phase_reg)
                    PH_BYTE0:
                    begin
                        saved_fin_next      = b[7];
                        saved_reserved_next = b[6:4];
                        saved_opcode_next   = b[3:0];
                        parse_phase_next    = PH_BYTE1;
                    end
                    PH_BYTE1:
                    begin
                        saved_masked_next       = b[7];
                        mask_key_next           = 32'd0;
                        length_accumulator_next = 64'd0;
                        header_index_next       = 4'd0;
                        if (saved_reserved_reg != 3'd0)
                        begin
                            error_latched_next = 1'b1;
                            latched_code_next  = ERR_RESERVED;
                            o_kind             = KIND_ERROR;
                            o_err              = ERR_RESERVED;
                        end
                        else if (b[6:0] == LEN_EXT16)
                            parse_phase_next = PH_EXT16;
                        else if (b[6:0] == LEN_EXT64)
                            parse_phase_next = PH_EXT64;
                        else
                        begin
                            length_accumulator_next = {57'd0, b[6:0]};
                            if (b[7])
                                parse_phase_next = PH_KEY;
                            else
                            begin
                                hd_go     = 1'b1;
                                hd_len    = {57'd0, b[6:0]};
                                hd_masked = 1'b0;
                            end
                        end
                    end
                    PH_EXT16, PH_EXT64:
                    begin
                        length_accumulator_next = acc_shift;
                        header_index_next       = hdr_idx_inc;
                        if ((parse_phase_reg == PH_EXT16 && hdr_idx_inc >= 4'd2) ||
                            hdr_idx_inc >= 4'd8)
                        begin
                            header_index_next = 4'd0;
                            if (saved_masked_reg)
                                parse_phase_next = PH_KEY;
                            else
                            begin
                                hd_go  = 1'b1;
                                hd_len = acc_shift;
                            end
                        end
                    end
                    PH_KEY:
                    begin
                        mask_key_next     = {mask_key_reg[23:0], b};
                        header_index_next = hdr_idx_inc;
                        if (hdr_idx_inc >= 4'd4)
                            hd_go = 1'b1;
                    end
                    PH_PAYLOAD:
                    begin
                        mask_position_next = mask_position_reg + 2'd1;
                        o_kind = frame_is_control_reg ? KIND_CONTROL : KIND_DATA;
                        o_byte = saved_masked_reg ? (b ^ key_byte) : b;
                        if (rem_last)
                        begin
                            bytes_remaining_next = 64'd0;
                            parse_phase_next     = PH_BYTE0;
                            o_last               = 1'b1;
                            ctrl_end             = frame_is_control_reg;
                        end
                        else
                            bytes_remaining_next = bytes_remaining_reg - 64'd1;
                    end
                    default:
                        parse_phase_next = PH_BYTE0;
                endcase
            end
        end

        if (hd_go)
        begin
            if (hd_bad)
            begin
                error_latched_next = 1'b1;
                latched_code_next  = hd_code;
                o_kind             = KIND_ERROR;
                o_err              = hd_code;
            end
            else
            begin
                frame_is_control_next = hd_ctl;
                mask_position_next    = 2'd0;
                bytes_remaining_next  = hd_len;
                header_index_next     = 4'd0;
                if (hd_len == 64'd0)
                begin
                    parse_phase_next = PH_BYTE0;
                    o_last           = 1'b1;
                    ctrl_end         = hd_ctl;
                end
                else
                    parse_phase_next = PH_PAYLOAD;
            end
        end

        if (ctrl_end)
        begin
            case (saved_opcode_reg)
                OP_PING:  o_action = ACT_PONG;
                OP_PONG:  o_action = ACT_PONG_SEEN;
                OP_CLOSE:
                begin
                    close_received_next = 1'b1;
                    if (!close_sent_reg)
                    begin
                        close_sent_next = 1'b1;
                        o_action        = ACT_CLOSE;
                    end
                end
                default:
                begin
                    // unknown control opcode: error replaces the result of the frame's last byte
                    error_latched_next = 1'b1;
                    latched_code_next  = ERR_UNKNOWN_OP;
                    o_kind             = KIND_ERROR;
                    o_byte             = 8'd0;
                    o_err              = ERR_UNKNOWN_OP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg        <= PH_BYTE0;
            header_index_reg       <= 4'd0;
            saved_opcode_reg       <= 4'd0;
            saved_fin_reg          <= 1'b0;
            saved_masked_reg       <= 1'b0;
            saved_reserved_reg     <= 3'd0;
            length_accumulator_reg <= 64'd0;
            mask_key_reg           <= 32'd0;
            mask_position_reg      <= 2'd0;
            bytes_remaining_reg    <= 64'd0;
            frame_is_control_reg   <= 1'b0;
            close_received_reg     <= 1'b0;
            close_sent_reg         <= 1'b0;
            error_latched_reg      <= 1'b0;
            latched_code_reg       <= 3'd0;
        end
        else if (step)
        begin
            parse_phase_reg        <= parse_phase_next;
            header_index_reg       <= header_index_next;
            saved_opcode_reg       <= saved_opcode_next;
            saved_fin_reg          <= saved_fin_next;
            saved_masked_reg       <= saved_masked_next;
            saved_reserved_reg     <= saved_reserved_next;
            length_accumulator_reg <= length_accumulator_next;
            mask_key_reg           <= mask_key_next;
            mask_position_reg      <= mask_position_next;
            bytes_remaining_reg    <= bytes_remaining_next;
            frame_is_control_reg   <= frame_is_control_next;
            close_received_reg     <= close_received_next;
            close_sent_reg         <= close_sent_next;
            error_latched_reg      <= error_latched_next;
            latched_code_reg       <= latched_code_next;
        end
    end

    assign res.result_kind    = o_kind;
    assign res.payload_byte   = o_byte;
    assign res.frame_opcode   = saved_opcode_next;
    assign res.frame_last     = o_last;
    assign res.control_action = o_action;
    assign res.error_code     = o_err;
    assign res.closed         = close_received_next;

endmodule

>>> hw/rtl/wsd_out.sv
// Result register with a skid entry, so input is taken while a result waits.
// Depends on wsd_pkg.
module wsd_out
    import wsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  out_t push_data,
    output logic can_push,
    output logic result_valid,
    input  logic result_ready,
    output out_t result
);

    logic main_valid_reg;
    logic skid_valid_reg;
    out_t main_reg;
    out_t skid_reg;
    logic pop;

    assign pop          = main_valid_reg & result_ready;
    assign can_push     = ~skid_valid_reg;
    assign result_valid = main_valid_reg;
    assign result       = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

endmodule

>>> hw/rtl/websocket_frame_deframer.sv
// WebSocket receive-side frame deframer, one event per transaction.
// Channels: item (event_kind, rx_byte) in, result (one per item) out, both
// valid/ready; configuration through an APB-style port, role_client at 0x0 and
// max_frame_length at 0x4, to be written only while the block is idle.
// Each accepted item is parsed against the frame state in the same cycle and
// its result is registered in wsd_out before it shows on result_valid.
// Throughput is one item per cycle while item_ready is high; the step logic is a
// single pass of header decode, 64-bit length compares, a decrement and an XOR.
// The result register has a skid entry behind it, so one more item is taken
// while a result waits; item_ready drops only when both entries are full
// and rises the cycle after the receiver takes a result.
// Reset (rst_n, asynchronous) returns the parser to the first header byte,
// clears the sticky error and close flags, sets role_client to 0 and
// max_frame_length to 64 MiB, and empties the result stage.
// Depends on wsd_pkg, wsd_cfg, wsd_core, wsd_out.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  in_t         item,
    output logic        result_valid,
    input  logic        result_ready,
    output out_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    out_t step_res;
    logic accept;

    assign accept = item_valid & item_ready;

    wsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wsd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .item  (item),
        .cfg   (cfg),
        .res   (step_res)
    );

    wsd_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .push_data    (step_res),
        .can_push     (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

>>> hw/rtl/wsd_checker.sv
// Port-level checker for the frame deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer_macros.svh.
`include "websocket_frame_deframer_macros.svh"

module wsd_checker
    import wsd_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready,
    input out_t result
);

    logic closed_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            closed_seen_reg <= 1'b0;
        else if (result_valid && result_ready && result.closed)
            closed_seen_reg <= 1'b1;
    end

    `WSD_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result changed while stalled")
    `WSD_ASSERT_IMP(a_ready_low_full, !item_ready, result_valid, "input stalled with no result pending")
    `WSD_ASSERT_IMP(a_closed_sticky, result_valid && closed_seen_reg, result.closed, "closed flag dropped")
    `WSD_ASSERT_IMP(a_action_at_end, result_valid && result.control_action != ACT_NONE, result.frame_last && (result.result_kind == KIND_CONTROL || result.result_kind == KIND_NONE), "control action off a frame end")
    `WSD_ASSERT_IMP(a_err_code_kind, result_valid && result.error_code != 3'd0, result.result_kind == KIND_ERROR, "error code without error kind")

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

>>> tb/tb.sv
// Self-checking bench for websocket_frame_deframer: random and directed frame streams,
// predicted result per transaction, APB register writes between phases.
// Depends on wsd_pkg and the deframer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam logic [1:0] EV_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 150000;
    localparam int HOLD_CYCLES = 250;

    typedef enum logic [2:0] {PH_HDR0, PH_HDR1, PH_LEN16, PH_LEN64, PH_KEY, PH_DATA} parse_e;
    typedef enum int {ENC_SHORT, ENC_16, ENC_64} len_enc_e;
    typedef enum int {END_ERROR, END_CLOSE_ECHO, END_CLOSE_QUIET, END_STREAM} ending_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    in_t         item = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    out_t        result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    websocket_frame_deframer dut (
        .clk, .rst_n,
        .item_valid, .item_ready, .item,
        .result_valid, .result_ready, .result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // predictor copy of the configuration and parser state
    logic        cfg_role = 1'b0;
    logic [31:0] cfg_max_len = MAX_LENGTH_RESET;
    parse_e      st_phase = PH_HDR0;
    logic [3:0]  st_hdr_idx = '0;
    logic [3:0]  st_opcode = '0;
    logic        st_fin = 1'b0;
    logic        st_masked = 1'b0;
    logic [2:0]  st_rsv = '0;
    logic [63:0] st_len = '0;
    logic [31:0] st_key = '0;
    logic [1:0]  st_key_pos = '0;
    logic [63:0] st_left = '0;
    logic        st_is_ctrl = 1'b0;
    logic        st_peer_closed = 1'b0;
    logic        st_local_closed = 1'b0;
    logic        st_err_on = 1'b0;
    logic [2:0]  st_err_code = '0;

    in_t  rx_stream[$];
    out_t owed_results[$];
    int   queued = 0;
    int   taken_count = 0;
    int   checked_count = 0;
    int   cycle_count = 0;
    int   failures = 0;
    int   hold_left = 0;
    bit   hold_done = 1'b0;
    bit   item_taken = 1'b0;
    bit   noisy = 1'b0;
    logic steady;

    // a window of the run with no gaps on either side
    assign steady = (taken_count >= 600) && (taken_count < 1000);

    initial
    begin
        forever #1 clk = ~clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("ERROR %s: got 0x%0h, expected 0x%0h (result %0d)",
                 what, got, want, checked_count);
        failures++;
    endtask

    function automatic void latch_error(input logic [2:0] code, inout out_t r);
        st_err_on = 1'b1;
        st_err_code = code;
        r.result_kind = KIND_ERROR;
        r.payload_byte = '0;
        r.error_code = code;
        r.control_action = ACT_NONE;
    endfunction

    function automatic void control_done(inout out_t r);
        case (st_opcode)
            OP_PING: r.control_action = ACT_PONG;
            OP_PONG: r.control_action = ACT_PONG_SEEN;
            OP_CLOSE:
            begin
                st_peer_closed = 1'b1;
                if (!st_local_closed)
                begin
                    st_local_closed = 1'b1;
                    r.control_action = ACT_CLOSE;
                end
            end
            default: latch_error(ERR_UNKNOWN_OP, r);
        endcase
    endfunction

    // header checks run in order of the error codes
    function automatic void header_done(inout out_t r);
        logic ctl;
        ctl = st_opcode[3];
        if (cfg_role == st_masked)
            latch_error(ERR_MASK_ROLE, r);
        else if (ctl && (!st_fin || st_len > CTRL_MAX_LEN))
            latch_error(ERR_BAD_CTRL, r);
        else if (!ctl && st_opcode != OP_BINARY && st_opcode != OP_CONT)
            latch_error(ERR_DATA_OP, r);
        else if (st_len > {32'b0, cfg_max_len})
            latch_error(ERR_OVERSIZE, r);
        else
        begin
            st_is_ctrl = ctl;
            st_key_pos = '0;
            st_left = st_len;
            st_hdr_idx = '0;
            if (st_len == 0)
            begin
                st_phase = PH_HDR0;
                r.frame_last = 1'b1;
                if (ctl)
                    control_done(r);
            end
            else
                st_phase = PH_DATA;
        end
    endfunction

    function automatic void length_done(inout out_t r);
        st_hdr_idx = '0;
        if (st_masked)
            st_phase = PH_KEY;
        else
            header_done(r);
    endfunction

    function automatic void parse_byte(input logic [7:0] b, inout out_t r);
        case (st_phase)
            PH_HDR0:
            begin
                st_fin = b[7];
                st_rsv = b[6:4];
                st_opcode = b[3:0];
                st_phase = PH_HDR1;
            end
            PH_HDR1:
            begin
                st_masked = b[7];
                st_key = '0;
                st_len = '0;
                st_hdr_idx = '0;
                if (st_rsv != 3'b000)
                    latch_error(ERR_RESERVED, r);
                else if (b[6:0] == LEN_EXT16)
                    st_phase = PH_LEN16;
                else if (b[6:0] == LEN_EXT64)
                    st_phase = PH_LEN64;
                else
                begin
                    st_len = {57'b0, b[6:0]};
                    length_done(r);
                end
            end
            PH_LEN16, PH_LEN64:
            begin
                st_len = {st_len[55:0], b};
                st_hdr_idx = st_hdr_idx + 4'd1;
                if (st_hdr_idx >= ((st_phase == PH_LEN16) ? 4'd2 : 4'd8))
                    length_done(r);
            end
            PH_KEY:
            begin
                st_key = {st_key[23:0], b};
                st_hdr_idx = st_hdr_idx + 4'd1;
                if (st_hdr_idx >= 4'd4)
                    header_done(r);
            end
            PH_DATA:
            begin
                r.result_kind = st_is_ctrl ? KIND_CONTROL : KIND_DATA;
                r.payload_byte = st_masked ? (b ^ st_key[8 * (3 - st_key_pos) +: 8]) : b;
                st_key_pos = st_key_pos + 2'd1;
                if (st_left != 0)
                    st_left = st_left - 64'd1;
                if (st_left == 0)
                begin
                    st_phase = PH_HDR0;
                    r.frame_last = 1'b1;
                    if (st_is_ctrl)
                        control_done(r);
                end
            end
            default: st_phase = PH_HDR0;
        endcase
    endfunction

    function automatic out_t deframe(input in_t it);
        out_t r;
        r = '0;
        case (it.event_kind)
            EV_CLOSE_SENT: st_local_closed = 1'b1;
            EV_STREAM_END: st_peer_closed = 1'b1;
            EV_BYTE:
            begin
                // sticky error wins over closed
                if (st_err_on)
                begin
                    r.result_kind = KIND_ERROR;
                    r.error_code = st_err_code;
                end
                else if (st_peer_closed)
                    r.result_kind = KIND_IGNORED;
                else
                    parse_byte(it.rx_byte, r);
            end
            default: ;
        endcase
        r.frame_opcode = st_opcode;
        r.closed = st_peer_closed;
        return r;
    endfunction

    // stimulus builders
    task automatic push_item(input logic [1:0] kind, input logic [7:0] b);
        in_t x;
        if (noisy && kind == EV_BYTE && $urandom_range(99) < 2)
        begin
            x.event_kind = EV_UNUSED;
            x.rx_byte = 8'($urandom);
            rx_stream.push_back(x);
        end
        x.event_kind = kind;
        x.rx_byte = b;
        rx_stream.push_back(x);
        queued++;
    endtask

    task automatic queue_body(input int n);
        for (int i = 0; i < n; i++)
            push_item(EV_BYTE, 8'($urandom));
    endtask

    task automatic queue_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                                input logic masked, input logic [63:0] len,
                                input len_enc_e enc);
        logic [31:0] key;
        key = $urandom;
        push_item(EV_BYTE, {fin, rsv, op});
        if (enc == ENC_SHORT)
            push_item(EV_BYTE, {masked, len[6:0]});
        else if (enc == ENC_16)
        begin
            push_item(EV_BYTE, {masked, LEN_EXT16});
            push_item(EV_BYTE, len[15:8]);
            push_item(EV_BYTE, len[7:0]);
        end
        else
        begin
            push_item(EV_BYTE, {masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                push_item(EV_BYTE, len[8 * i +: 8]);
        end
        if (masked)
            for (int i = 3; i >= 0; i--)
                push_item(EV_BYTE, key[8 * i +: 8]);
    endtask

    // well-formed frame for the current role, length within the current limit
    task automatic queue_random_frame();
        logic [3:0]  op;
        logic        fin;
        logic [63:0] len;
        len_enc_e    enc;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 25)
        begin
            op = $urandom_range(1) ? OP_PING : OP_PONG;
            fin = 1'b1;
            len = (roll < 5) ? CTRL_MAX_LEN : 64'($urandom_range(0, 20));
        end
        else
        begin
            op = $urandom_range(1) ? OP_BINARY : OP_CONT;
            fin = 1'($urandom_range(1));
            len = (roll > 92) ? 64'($urandom_range(126, 400)) : 64'($urandom_range(0, 24));
        end
        if (len > {32'b0, cfg_max_len})
            len = {32'b0, cfg_max_len};
        roll = $urandom_range(99);
        if (len > CTRL_MAX_LEN)
            enc = (roll < 85) ? ENC_16 : ENC_64;
        else
            enc = (roll < 85) ? ENC_SHORT : ((roll < 93) ? ENC_16 : ENC_64);
        queue_header(fin, 3'b000, op, !cfg_role, len, enc);
        queue_body(int'(len));
    endtask

    task automatic write_register(input logic idx, input logic [31:0] val);
        logic [31:0] want;
        want = (idx == REG_ROLE_CLIENT) ? {31'b0, val[0]} : val;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_ROLE_CLIENT)
            cfg_role = val[0];
        else
            cfg_max_len = val;
        // read back: psel stays high into the next setup
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
            report("register readback", 64'(prdata), 64'(want));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic role, input logic [31:0] max_len);
        write_register(REG_ROLE_CLIENT, {31'b0, role});
        write_register(REG_MAX_LENGTH, max_len);
    endtask

    task automatic wait_idle();
        while (rx_stream.size() != 0 || item_valid || owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender: next transaction offered once the previous one has gone
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            item_taken = 1'b0;
            if (rx_stream.size() != 0 && (steady || $urandom_range(99) >= 36))
            begin
                item <= rx_stream.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (!hold_done && taken_count >= 1300)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else
            result_ready <= steady || ($urandom_range(99) >= 36);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && item_valid && item_ready)
        begin
            owed_results.push_back(deframe(item));
            taken_count++;
            item_taken = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (owed_results.size() == 0)
                report("result with nothing outstanding", 64'(result), 64'd0);
            else
            begin
                want = owed_results.pop_front();
                if (result.result_kind !== want.result_kind)
                    report("result_kind", 64'(result.result_kind), 64'(want.result_kind));
                if (result.payload_byte !== want.payload_byte)
                    report("payload_byte", 64'(result.payload_byte), 64'(want.payload_byte));
                if (result.frame_opcode !== want.frame_opcode)
                    report("frame_opcode", 64'(result.frame_opcode), 64'(want.frame_opcode));
                if (result.frame_last !== want.frame_last)
                    report("frame_last", 64'(result.frame_last), 64'(want.frame_last));
                if (result.control_action !== want.control_action)
                    report("control_action", 64'(result.control_action),
                           64'(want.control_action));
                if (result.error_code !== want.error_code)
                    report("error_code", 64'(result.error_code), 64'(want.error_code));
                if (result.closed !== want.closed)
                    report("closed", 64'(result.closed), 64'(want.closed));
            end
            checked_count++;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int          quota;
        int          roll;
        int          len;
        logic [3:0]  op;
        logic [2:0]  code;
        ending_e     ending;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset config (server, frames masked)
        queue_header(1'b1, 3'b000, OP_BINARY, 1'b1, 64'd3, ENC_SHORT);
        queue_body(3);
        push_item(EV_UNUSED, 8'hFF);
        queue_header(1'b1, 3'b000, OP_PING, 1'b1, 64'd0, ENC_SHORT);
        // non-minimal extended length
        queue_header(1'b0, 3'b000, OP_CONT, 1'b1, 64'd1, ENC_16);
        queue_body(1);
        wait_idle();

        noisy = 1'b1;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_config(1'b0, 32'hFFFF_FFFF);
                1: set_config(1'b1, 32'($urandom_range(126, 600)));
                2: set_config(1'b0, 32'd0);
                3: set_config(1'b1, MAX_LENGTH_RESET);
                default: set_config(1'b0, 32'($urandom_range(1, 40)));
            endcase
            quota = queued + 340;
            while (queued < quota)
                queue_random_frame();
            wait_idle();
        end

        // the run ends in a sticky state: one error, a close, or end of stream
        roll = $urandom_range(9);
        ending = (roll < 6) ? END_ERROR : (roll == 6) ? END_CLOSE_ECHO :
                 (roll == 7) ? END_CLOSE_QUIET : END_STREAM;
        case (ending)
            END_ERROR:
            begin
                code = 3'($urandom_range(5));
                case (code)
                    ERR_RESERVED:
                        queue_header(1'b1, 3'($urandom_range(1, 7)), OP_BINARY, !cfg_role,
                                     64'd2, ENC_SHORT);
                    ERR_MASK_ROLE:
                        queue_header(1'b1, 3'b000, OP_BINARY, cfg_role, 64'd2, ENC_SHORT);
                    ERR_BAD_CTRL:
                        if ($urandom_range(1))
                            queue_header(1'b0, 3'b000, OP_PING, !cfg_role, 64'd3, ENC_SHORT);
                        else
                            queue_header(1'b1, 3'b000, OP_PONG, !cfg_role,
                                         64'($urandom_range(126, 300)), ENC_16);
                    ERR_DATA_OP:
                    begin
                        op = 4'($urandom_range(1, 6));
                        if (op >= OP_BINARY)
                            op = op + 4'd1;
                        queue_header(1'b1, 3'b000, op, !cfg_role, 64'd2, ENC_SHORT);
                    end
                    ERR_OVERSIZE:
                        queue_header(1'b1, 3'b000, OP_BINARY, !cfg_role,
                                     {32'b0, cfg_max_len} + 64'd1, ENC_64);
                    default:
                    begin
                        // unknown control opcode: payload streams, error on the last byte
                        len = $urandom_range(0, 5);
                        queue_header(1'b1, 3'b000, OP_PONG + 4'($urandom_range(1, 5)),
                                     !cfg_role, 64'(len), ENC_SHORT);
                        queue_body(len);
                    end
                endcase
                queue_body(4);
                push_item(EV_STREAM_END, 8'($urandom));
                queue_body(4);
            end
            END_CLOSE_ECHO, END_CLOSE_QUIET:
            begin
                if (ending == END_CLOSE_QUIET)
                    push_item(EV_CLOSE_SENT, 8'($urandom));
                len = $urandom_range(0, 10);
                if (len > cfg_max_len)
                    len = cfg_max_len;
                queue_header(1'b1, 3'b000, OP_CLOSE, !cfg_role, 64'(len), ENC_SHORT);
                queue_body(len);
                queue_body(3);
                push_item(EV_CLOSE_SENT, 8'($urandom));
                push_item(EV_UNUSED, 8'($urandom));
                queue_body(3);
            end
            default:
            begin
                // peer stream ends in the middle of a frame
                queue_header(1'b1, 3'b000, OP_BINARY, !cfg_role, 64'd6, ENC_SHORT);
                queue_body(2);
                push_item(EV_STREAM_END, 8'($urandom));
                queue_body(5);
            end
        endcase
        wait_idle();

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> websocket_frame_deframer.f
+incdir+hw/rtl
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_cfg.sv
hw/rtl/wsd_core.sv
hw/rtl/wsd_out.sv
hw/rtl/websocket_frame_deframer.sv
hw/rtl/wsd_checker.sv
tb/tb.sv
